// ===== rtl/puud_pkg.sv =====
// Shared constants, result type and hex helpers for the percent/unicode unescape decoder.
`timescale 1ns / 1ps

package puud_pkg;

	localparam int COUNT_BITS = 17;
	localparam int LEN_W      = 17;
	localparam int CAP_W      = 16;
	localparam int WIN_DEPTH  = 6;
	localparam int WIN_IDX_W  = 3;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [CAP_W-1:0]      CAP_RESET = '1;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CH_UP_U  = 8'h55;
	localparam logic [7:0] UTF_LEAD = 8'he0;
	localparam logic [7:0] UTF_CONT = 8'h80;

	// Window fill levels that gate each escape form.
	localparam logic [WIN_IDX_W-1:0] FILL_PCT_HH = 3'd3;
	localparam logic [WIN_IDX_W-1:0] FILL_PCT_U  = 3'd2;
	localparam logic [WIN_IDX_W-1:0] FILL_FULL   = 3'd6;

	typedef struct packed {
		logic [7:0]       data;
		logic             valid;
		logic             eos;
		logic             status;
		logic [LEN_W-1:0] length;
	} puud_res_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
			|| ((c >= 8'h41) && (c <= 8'h46));
		return r;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] r;
		r = 8'h00;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			r = c - 8'h30;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			r = c - 8'h57;
		end else if ((c >= 8'h41) && (c <= 8'h46)) begin
			r = c - 8'h37;
		end
		return r[3:0];
	endfunction

endpackage

// ===== rtl/percent_unicode_unescape_decoder.sv =====
// Top level of the percent/unicode unescape decoder: window, step sequencer and output stage.
`timescale 1ns / 1ps

// Undoes escaping on a byte stream framed by tlast. "%uHHHH" (u in either case) becomes
// the three-byte UTF-8 form of the 16-bit value, "%HH" becomes one byte, and a '%' that
// starts neither passes through literally. Up to five bytes of an undecided escape are
// held between requests. Each accepted request is loaded into a six-byte window and one
// shared decode step runs per cycle under a small sequencer; every step produces at most
// one result, and the last result of a request carries tlast. A request is accepted,
// then runs a step for each decoded byte and a step that finds the window empty, stopped
// or undecided, and closes with the end step and the release of the last pending result;
// a stall on the result side holds the sequencer. Each string closes with one end result
// (tuser stream_end set) carrying the status (1 for a '%' left at the tail alone or with
// one byte other than u) and the decoded length. Decoding stops once the length reaches
// cfg_wdata's capacity register (reset 65535), checked before each escape or literal; a
// started three-byte group is finished. Write the capacity only while the block is idle.
module percent_unicode_unescape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [24:8] length, [31:25] zero
	output logic [2:0]  m_axis_tuser,   // [0] byte_valid, [1] stream_end, [2] status
	output logic        m_axis_tlast,   // run_last
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata        // output_capacity
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_UNI2,
		ST_UNI3,
		ST_END,
		ST_FLUSH
	} state_t;

	state_t state_q;

	// Window of held bytes plus the new byte, always left aligned.
	logic [7:0]                          win_q [puud_pkg::WIN_DEPTH];
	logic [puud_pkg::WIN_IDX_W-1:0]      fill_q;
	logic                                last_q;
	logic                                err_q;
	logic                                stopped_q;
	logic [puud_pkg::COUNT_BITS-1:0]     count_q;
	logic [puud_pkg::CAP_W-1:0]          cap_q;

	// One result waits in pend_q until it is known whether another follows.
	puud_pkg::puud_res_t                 pend_q;
	logic                                pend_v_q;
	puud_pkg::puud_res_t                 out_q;
	logic                                out_v_q;
	logic                                out_last_q;

	logic                                out_free;

	// Next results and the move of pend into the output stage
	puud_pkg::puud_res_t                 emit_res;
	puud_pkg::puud_res_t                 end_res;
	logic                                out_load;
	logic                                out_load_last;

	// Decode step outputs
	logic                                step_emit;
	logic [7:0]                          step_byte;
	logic [2:0]                          step_shift;
	state_t                              step_next;
	logic                                step_stop;
	logic                                step_err;

	logic                                bad_u;
	logic                                partial_u;
	logic                                is_u;
	logic [3:0]                          hv2, hv3, hv4, hv5;
	logic [7:0]                          uni_b1, uni_b2, uni_b3;

	assign out_free      = !out_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, out_q.length, out_q.data};
	assign m_axis_tuser  = {out_q.status, out_q.eos, out_q.valid};

	assign hv2 = puud_pkg::hex_val(win_q[2]);
	assign hv3 = puud_pkg::hex_val(win_q[3]);
	assign hv4 = puud_pkg::hex_val(win_q[4]);
	assign hv5 = puud_pkg::hex_val(win_q[5]);

	// 1110xxxx 10xxxxxx 10xxxxxx from the four hex digits
	assign uni_b1 = puud_pkg::UTF_LEAD | {4'd0, hv2};
	assign uni_b2 = puud_pkg::UTF_CONT | {2'd0, hv3, hv4[3:2]};
	assign uni_b3 = puud_pkg::UTF_CONT | {2'd0, hv4[1:0], hv5};

	assign is_u = (win_q[1] == puud_pkg::CH_LOW_U) || (win_q[1] == puud_pkg::CH_UP_U);

	// Any present digit that is not hex spoils the unicode form; missing digits
	// leave it undecided.
	always_comb begin
		bad_u = 1'b0;
		for (int k = 2; k < puud_pkg::WIN_DEPTH; k++) begin
			if ((puud_pkg::WIN_IDX_W'(k) < fill_q) && !puud_pkg::is_hex(win_q[k])) begin
				bad_u = 1'b1;
			end
		end
		partial_u = (fill_q < puud_pkg::FILL_FULL);
	end

	// One decode step at the head of the window.
	always_comb begin
		step_emit  = 1'b0;
		step_byte  = 8'd0;
		step_shift = 3'd0;
		step_next  = ST_RUN;
		step_stop  = 1'b0;
		step_err   = 1'b0;
		if (stopped_q || (fill_q == '0)) begin
			step_next = ST_END;
		end else if (32'(count_q) >= 32'(cap_q)) begin
			step_stop = 1'b1;
			step_next = ST_END;
		end else if (win_q[0] != puud_pkg::CH_PCT) begin
			step_emit  = 1'b1;
			step_byte  = win_q[0];
			step_shift = 3'd1;
		end else if (fill_q < puud_pkg::FILL_PCT_U) begin
			step_err  = last_q;
			step_next = ST_END;
		end else if (is_u) begin
			if (bad_u || (partial_u && last_q)) begin
				step_emit  = 1'b1;
				step_byte  = puud_pkg::CH_PCT;
				step_shift = 3'd1;
			end else if (partial_u) begin
				step_next = ST_END;
			end else begin
				step_emit = 1'b1;
				step_byte = uni_b1;
				step_next = ST_UNI2;
			end
		end else if (fill_q < puud_pkg::FILL_PCT_HH) begin
			step_err  = last_q;
			step_next = ST_END;
		end else if (puud_pkg::is_hex(win_q[1]) && puud_pkg::is_hex(win_q[2])) begin
			step_emit  = 1'b1;
			step_byte  = {puud_pkg::hex_val(win_q[1]), puud_pkg::hex_val(win_q[2])};
			step_shift = 3'd3;
		end else begin
			step_emit  = 1'b1;
			step_byte  = puud_pkg::CH_PCT;
			step_shift = 3'd1;
		end
	end

	// Data result of this cycle's step and the end result of the string.
	always_comb begin
		emit_res       = '0;
		emit_res.valid = 1'b1;
		case (state_q)
			ST_UNI2: begin
				emit_res.data = uni_b2;
			end
			ST_UNI3: begin
				emit_res.data = uni_b3;
			end
			default: begin
				emit_res.data = step_byte;
			end
		endcase
		end_res        = '0;
		end_res.eos    = 1'b1;
		end_res.status = err_q;
		end_res.length = puud_pkg::LEN_W'(count_q);
	end

	// Advance pend into the output stage whenever a newer result replaces it
	// or the request closes.
	always_comb begin
		out_load      = 1'b0;
		out_load_last = 1'b0;
		case (state_q) inside
			ST_RUN, ST_UNI2, ST_UNI3: begin
				out_load = out_free && pend_v_q && ((state_q != ST_RUN) || step_emit);
			end
			ST_END: begin
				out_load = out_free && pend_v_q && last_q;
			end
			ST_FLUSH: begin
				out_load      = out_free && pend_v_q;
				out_load_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Window contents carry no reset; only entries below fill_q are ever read.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (s_axis_tvalid) begin
				win_q[fill_q] <= s_axis_tdata;
			end
		end else if ((state_q == ST_RUN) && out_free) begin
			for (int i = 0; i < puud_pkg::WIN_DEPTH; i++) begin
				case (step_shift)
					3'd1: begin
						if (i + 1 < puud_pkg::WIN_DEPTH) begin
							win_q[i] <= win_q[i+1];
						end
					end
					3'd3: begin
						if (i + 3 < puud_pkg::WIN_DEPTH) begin
							win_q[i] <= win_q[i+3];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			last_q     <= 1'b0;
			err_q      <= 1'b0;
			stopped_q  <= 1'b0;
			count_q    <= '0;
			cap_q      <= puud_pkg::CAP_RESET;
			pend_q     <= '0;
			pend_v_q   <= 1'b0;
			out_q      <= '0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end

			// Load the output register from pend, else drain it when taken.
			if (out_load) begin
				out_q      <= pend_q;
				out_v_q    <= 1'b1;
				out_last_q <= out_load_last;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q) inside
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						fill_q  <= fill_q + 3'd1;
						last_q  <= s_axis_tlast;
						err_q   <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN, ST_UNI2, ST_UNI3: begin
					if (out_free) begin
						if ((state_q != ST_RUN) || step_emit) begin
							// Hold the new result until the next one shows up.
							pend_v_q <= 1'b1;
							pend_q   <= emit_res;
							if (count_q != puud_pkg::COUNT_MAX) begin
								count_q <= count_q + puud_pkg::COUNT_BITS'(1);
							end
						end
						unique case (state_q)
							ST_RUN: begin
								fill_q      <= fill_q - step_shift;
								state_q     <= step_next;
								if (step_stop) begin
									stopped_q <= 1'b1;
								end
								if (step_err) begin
									err_q <= 1'b1;
								end
							end
							ST_UNI2: begin
								state_q     <= ST_UNI3;
							end
							default: begin
								fill_q      <= fill_q - 3'd6;
								state_q     <= ST_RUN;
							end
						endcase
					end
				end
				ST_END: begin
					if (out_free) begin
						if (stopped_q || err_q || last_q) begin
							fill_q <= '0;
						end
						if (last_q) begin
							pend_v_q      <= 1'b1;
							pend_q        <= end_res;
							count_q       <= '0;
							stopped_q     <= 1'b0;
						end
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						// Release the final result of this request with tlast.
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
